[rtl/rmdc_pkg.sv]
// Shared types and constants for the maze carver.
package rmdc_pkg;

	localparam int ROWS_DEF = 11;
	localparam int COLS_DEF = 11;

	// width of the visited-store epoch tag
	localparam int EP_W = 4;

	// directions tried per frame before it is exhausted
	localparam logic [2:0] TRIES_ALL = 3'd4;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_ENTER = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_EAST  = 2'd0,
		DIR_SOUTH = 2'd1,
		DIR_WEST  = 2'd2,
		DIR_NORTH = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_ENTER,
		S_TRY,
		S_POP,
		S_CHK,
		S_RES
	} state_t;

endpackage

[rtl/random_maze_dfs_carver_top.sv]
// Randomised depth-first maze carver: control, visited store and walk stack.
//
//  channel | valid     | stall     | beat fields
//  --------+-----------+-----------+----------------------------------------------
//  in      | in_valid  | in_stall  | command start_row start_col turn_bit first_dir
//  out     | out_valid | out_stall | wall_row wall_col next_row next_col done_res
//
// Flow: after acceptance ENTER marks and pushes the entered cell; each in-grid direction
// tried passes TRY (store read) and CHK (tag compare), an off-grid one TRY, a popped
// frame TRY and POP (bottom frame TRY, then TRY to see the stack empty); RES loads the
// result register. Reset: a clearing pass writes tag zero to the visited store with the
// input stalled; a start beat reruns it once every 2**EP_W-1 starts, when the tag wraps.
// Stalls: one beat at a time; the next input beat is taken while a result still waits.
module random_maze_dfs_carver_top #(
	parameter int ROWS = rmdc_pkg::ROWS_DEF,
	parameter int COLS = rmdc_pkg::COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [3:0] start_row,
	input  logic [3:0] start_col,
	input  logic       turn_bit,
	input  logic [1:0] first_dir,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] wall_row,
	output logic [4:0] wall_col,
	output logic [3:0] next_row,
	output logic [3:0] next_col,
	output logic       done_res
);

	localparam int CELLS = ROWS * COLS;
	localparam int RW    = $clog2(ROWS + 2);   // holds 0..ROWS+1 for neighbours
	localparam int CW    = $clog2(COLS + 2);
	localparam int IW    = $clog2(CELLS);
	localparam int DW    = $clog2(CELLS + 1);
	localparam int EPW   = rmdc_pkg::EP_W;
	localparam int FW    = RW + CW + 6;        // row, col, turn, dir, tries
	localparam logic [EPW-1:0] EP_MAX = {EPW{1'b1}};

	// cell number from 1-based coordinates
	function automatic logic [IW-1:0] cell_idx(input logic [RW-1:0] r,
		input logic [CW-1:0] c);
		return IW'(32'(r - RW'(1)) * COLS + 32'(c - CW'(1)));
	endfunction

	rmdc_pkg::state_t state_q, state_nxt;

	// control registers
	logic [IW-1:0]  clr_q;
	logic [EPW-1:0] ep_q;
	logic [DW-1:0]  depth_q;
	logic           fin_q;
	logic [RW-1:0]  pend_r_q;
	logic [CW-1:0]  pend_c_q;
	logic           ovalid_q;

	// cell being entered
	logic [RW-1:0] ent_r_q;
	logic [CW-1:0] ent_c_q;
	logic          ent_turn_q;
	logic [1:0]    ent_dir_q;

	// top stack frame, kept in flops; frames below it live in the stack memory
	logic [RW-1:0] top_r_q;
	logic [CW-1:0] top_c_q;
	logic          top_turn_q;
	logic [1:0]    top_dir_q;
	logic [2:0]    top_tries_q;

	// neighbour under test and its wall
	logic [RW-1:0] nb_r_q;
	logic [CW-1:0] nb_c_q;
	logic [4:0]    wall_r_q;
	logic [4:0]    wall_c_q;
	logic          res_done_q;

	// output register
	logic [4:0] owall_r_q, owall_c_q;
	logic [3:0] onext_r_q, onext_c_q;
	logic       odone_q;

	// memories
	logic [EPW-1:0] vis_mem [CELLS];
	logic [FW-1:0]  stk_mem [CELLS];
	logic           vis_we, vis_re, stk_we, stk_re;
	logic [IW-1:0]  vis_waddr, vis_raddr, stk_waddr, stk_raddr;
	logic [EPW-1:0] vis_wdata, vis_rdata_q;
	logic [FW-1:0]  stk_wdata, stk_rdata_q;

	// neighbour arithmetic
	logic [RW-1:0] nb_r;
	logic [CW-1:0] nb_c;
	logic [RW:0]   wall_r;
	logic [CW:0]   wall_c;
	logic          nb_in_grid;
	logic [1:0]    dir_adv;
	logic [RW-1:0] sat_r;
	logic [CW-1:0] sat_c;

	logic in_acc, is_start, do_push, top_done, stack_empty, nb_open, res_load;

	assign in_acc      = in_valid && !in_stall;
	assign is_start    = command == rmdc_pkg::CMD_START;
	assign do_push     = depth_q < DW'(CELLS);
	assign top_done    = top_tries_q == rmdc_pkg::TRIES_ALL;
	assign stack_empty = depth_q == '0;
	assign nb_open     = vis_rdata_q != ep_q;
	assign res_load    = !ovalid_q || !out_stall;
	assign dir_adv     = top_turn_q ? 2'd1 : 2'd3;

	always_comb begin
		nb_r   = top_r_q;
		nb_c   = top_c_q;
		wall_r = {top_r_q, 1'b0};
		wall_c = {top_c_q, 1'b0};
		unique case (rmdc_pkg::dir_t'(top_dir_q))
			rmdc_pkg::DIR_EAST: begin
				nb_c   = top_c_q + CW'(1);
				wall_c = {top_c_q, 1'b0} + (CW + 1)'(1);
			end
			rmdc_pkg::DIR_SOUTH: begin
				nb_r   = top_r_q + RW'(1);
				wall_r = {top_r_q, 1'b0} + (RW + 1)'(1);
			end
			rmdc_pkg::DIR_WEST: begin
				nb_c   = top_c_q - CW'(1);
				wall_c = {top_c_q, 1'b0} - (CW + 1)'(1);
			end
			rmdc_pkg::DIR_NORTH: begin
				nb_r   = top_r_q - RW'(1);
				wall_r = {top_r_q, 1'b0} - (RW + 1)'(1);
			end
			default: begin
				nb_r = top_r_q;
			end
		endcase
		nb_in_grid = nb_r != '0 && nb_r <= RW'(ROWS) && nb_c != '0 && nb_c <= CW'(COLS);
	end

	// start cell saturated into the grid
	always_comb begin
		priority if (start_row == 4'd0)
			sat_r = RW'(1);
		else if (int'(start_row) > ROWS)
			sat_r = RW'(ROWS);
		else
			sat_r = RW'(start_row);
		priority if (start_col == 4'd0)
			sat_c = CW'(1);
		else if (int'(start_col) > COLS)
			sat_c = CW'(COLS);
		else
			sat_c = CW'(start_col);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rmdc_pkg::S_CLR: begin
				if (clr_q == IW'(CELLS - 1))
					state_nxt = fin_q ? rmdc_pkg::S_IDLE : rmdc_pkg::S_ENTER;
			end
			rmdc_pkg::S_IDLE: begin
				if (in_acc) begin
					if (is_start)
						state_nxt = (ep_q == EP_MAX) ? rmdc_pkg::S_CLR : rmdc_pkg::S_ENTER;
					else
						state_nxt = fin_q ? rmdc_pkg::S_RES : rmdc_pkg::S_ENTER;
				end
			end
			rmdc_pkg::S_ENTER: state_nxt = rmdc_pkg::S_TRY;
			rmdc_pkg::S_TRY: begin
				priority if (stack_empty)
					state_nxt = rmdc_pkg::S_RES;
				else if (top_done)
					state_nxt = (depth_q > DW'(1)) ? rmdc_pkg::S_POP : rmdc_pkg::S_TRY;
				else if (nb_in_grid)
					state_nxt = rmdc_pkg::S_CHK;
				else
					state_nxt = rmdc_pkg::S_TRY;
			end
			rmdc_pkg::S_POP: state_nxt = rmdc_pkg::S_TRY;
			rmdc_pkg::S_CHK: state_nxt = nb_open ? rmdc_pkg::S_RES : rmdc_pkg::S_TRY;
			rmdc_pkg::S_RES: begin
				if (res_load)
					state_nxt = rmdc_pkg::S_IDLE;
			end
			default: state_nxt = rmdc_pkg::S_CLR;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		in_stall  = state_q != rmdc_pkg::S_IDLE;
		vis_we    = 1'b0;
		vis_waddr = clr_q;
		vis_wdata = '0;
		vis_re    = 1'b0;
		vis_raddr = cell_idx(nb_r, nb_c);
		stk_we    = 1'b0;
		stk_waddr = IW'(depth_q - DW'(1));
		stk_wdata = {top_r_q, top_c_q, top_turn_q, top_dir_q, top_tries_q};
		stk_re    = 1'b0;
		stk_raddr = IW'(depth_q - DW'(2));
		unique case (state_q)
			rmdc_pkg::S_CLR: vis_we = 1'b1;
			rmdc_pkg::S_ENTER: begin
				vis_we    = 1'b1;
				vis_waddr = cell_idx(ent_r_q, ent_c_q);
				vis_wdata = ep_q;
				stk_we    = do_push && !stack_empty;
			end
			rmdc_pkg::S_TRY: begin
				vis_re = !stack_empty && !top_done && nb_in_grid;
				stk_re = !stack_empty && top_done && depth_q > DW'(1);
			end
			default: begin
				vis_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (vis_we)
			vis_mem[vis_waddr] <= vis_wdata;
		if (vis_re)
			vis_rdata_q <= vis_mem[vis_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_waddr] <= stk_wdata;
		if (stk_re)
			stk_rdata_q <= stk_mem[stk_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rmdc_pkg::S_CLR;
			clr_q    <= '0;
			ep_q     <= '0;
			depth_q  <= '0;
			fin_q    <= 1'b1;
			pend_r_q <= '0;
			pend_c_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				rmdc_pkg::S_CLR: begin
					clr_q <= (clr_q == IW'(CELLS - 1)) ? '0 : clr_q + IW'(1);
				end
				rmdc_pkg::S_IDLE: begin
					if (in_acc && is_start) begin
						depth_q <= '0;
						fin_q   <= 1'b0;
						ep_q    <= (ep_q == EP_MAX) ? EPW'(1) : ep_q + EPW'(1);
					end
				end
				rmdc_pkg::S_ENTER: begin
					if (do_push)
						depth_q <= depth_q + DW'(1);
				end
				rmdc_pkg::S_TRY: begin
					if (stack_empty) begin
						fin_q    <= 1'b1;
						pend_r_q <= '0;
						pend_c_q <= '0;
					end else if (top_done) begin
						depth_q <= depth_q - DW'(1);
					end
				end
				rmdc_pkg::S_CHK: begin
					if (nb_open) begin
						pend_r_q <= nb_r_q;
						pend_c_q <= nb_c_q;
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
			if (state_q == rmdc_pkg::S_RES && res_load)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			rmdc_pkg::S_IDLE: begin
				if (in_acc) begin
					ent_r_q    <= is_start ? sat_r : pend_r_q;
					ent_c_q    <= is_start ? sat_c : pend_c_q;
					ent_turn_q <= turn_bit;
					ent_dir_q  <= first_dir;
					res_done_q <= 1'b1;
				end
			end
			rmdc_pkg::S_ENTER: begin
				if (do_push) begin
					top_r_q     <= ent_r_q;
					top_c_q     <= ent_c_q;
					top_turn_q  <= ent_turn_q;
					top_dir_q   <= ent_dir_q;
					top_tries_q <= '0;
				end
			end
			rmdc_pkg::S_TRY: begin
				if (stack_empty) begin
					res_done_q <= 1'b1;
				end else if (!top_done) begin
					top_tries_q <= top_tries_q + 3'd1;
					top_dir_q   <= top_dir_q + dir_adv;
					nb_r_q      <= nb_r;
					nb_c_q      <= nb_c;
					wall_r_q    <= 5'(wall_r);
					wall_c_q    <= 5'(wall_c);
					res_done_q  <= 1'b0;
				end
			end
			rmdc_pkg::S_POP: begin
				{top_r_q, top_c_q, top_turn_q, top_dir_q, top_tries_q} <= stk_rdata_q;
			end
			rmdc_pkg::S_RES: begin
				if (res_load) begin
					owall_r_q <= res_done_q ? 5'd0 : wall_r_q;
					owall_c_q <= res_done_q ? 5'd0 : wall_c_q;
					onext_r_q <= res_done_q ? 4'd0 : 4'(nb_r_q);
					onext_c_q <= res_done_q ? 4'd0 : 4'(nb_c_q);
					odone_q   <= res_done_q;
				end
			end
			default: begin
				res_done_q <= res_done_q;
			end
		endcase
	end

	assign out_valid = ovalid_q;
	assign wall_row  = owall_r_q;
	assign wall_col  = owall_c_q;
	assign next_row  = onext_r_q;
	assign next_col  = onext_c_q;
	assign done_res  = odone_q;

`ifndef NO_ASSERTIONS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(CELLS))
		else $error("stack depth beyond grid size");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |->
			wall_row == 5'd0 && wall_col == 5'd0 && next_row == 4'd0 && next_col == 4'd0)
		else $error("done beat carries non-zero coordinates");

	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		!fin_q |-> ep_q != '0)
		else $error("walk running with the reset epoch tag");

	a_open_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rmdc_pkg::S_CHK && nb_open |=> state_q == rmdc_pkg::S_RES && !fin_q)
		else $error("open neighbour did not produce a result");
`endif

endmodule
